// File: hdl/signed_int_to_custom_radix_text_defines.svh
// assertion macros for the signed integer to custom radix text block
// no dependencies; taken in by the top level with `include

`ifndef SIGNED_INT_TO_CUSTOM_RADIX_TEXT_DEFINES_SVH
`define SIGNED_INT_TO_CUSTOM_RADIX_TEXT_DEFINES_SVH

// same-cycle implication
`define SIRT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SIRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/sirt_pkg.sv
// shared types and constants for the signed integer to custom radix text block
// no dependencies

package sirt_pkg;

   localparam int VALUE_W     = 32;
   localparam int MAG_W       = 32;
   localparam int CHAR_W      = 8;
   localparam int CFG_W       = 64;
   localparam int SYM_WORDS   = 4;
   localparam int SYM_IDX_W   = 2;
   localparam int BYTES_PER_WORD = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int POW_DEPTH   = 32;
   localparam int POW_IDX_W   = 5;
   localparam int SHIFT_W     = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   // largest magnitude a word can carry
   localparam logic [MAG_W-1:0] POW_LIMIT = 32'h8000_0000;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } item_type;

   typedef struct packed {
      logic                 ready;
      logic                 valid;
      logic [POW_IDX_W-1:0] top;
      logic [SHIFT_W-1:0]   dbits;
   } alpha_stat_type;

   typedef enum logic [1:0] {
      A_SCAN,
      A_POW,
      A_DONE
   } alpha_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SIGN,
      B_SKIP,
      B_DIGIT
   } back_state_type;

endpackage

// File: hdl/sirt_front.sv
// front stage: takes a word, splits it into sign and magnitude
// depends on sirt_pkg

module sirt_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [sirt_pkg::VALUE_W-1:0] req_value,
   output logic                                push_valid,
   input  logic                                push_ready,
   output sirt_pkg::item_type                  push_item
);

   logic                          valid_ff, valid_in;
   sirt_pkg::item_type            item_ff, item_in;
   logic [sirt_pkg::MAG_W-1:0]    raw;

   assign raw       = $unsigned(req_value);
   assign req_ready = !valid_ff || push_ready;

   always_comb begin
      item_in.neg = raw[sirt_pkg::MAG_W-1];
      item_in.mag = item_in.neg ? (sirt_pkg::MAG_W'(0) - raw) : raw;
      valid_in    = (req_valid && req_ready) || (valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

// File: hdl/sirt_queue.sv
// two-entry queue between the front stage and the digit engine
// depends on sirt_pkg

module sirt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  sirt_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output sirt_pkg::item_type pop_item
);

   sirt_pkg::item_type                entry_ff [sirt_pkg::QUEUE_DEPTH];
   logic [sirt_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [sirt_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [sirt_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push, do_pop;

   assign push_ready = count_ff != sirt_pkg::QCNT_W'(sirt_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/sirt_alpha.sv
// alphabet registers, alphabet checker and table of radix powers
// depends on sirt_pkg

module sirt_alpha #(
   parameter int MAX_SYMBOLS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sirt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sirt_pkg::CFG_W-1:0]          csr_wdata,
   output sirt_pkg::alpha_stat_type            stat,
   input  logic [sirt_pkg::POW_IDX_W-1:0]      pow_idx,
   output logic [sirt_pkg::MAG_W-1:0]          pow_data,
   input  logic [$clog2(MAX_SYMBOLS)-1:0]      sym_idx,
   output logic [sirt_pkg::CHAR_W-1:0]         sym_data
);

   localparam int DIGIT_W = $clog2(MAX_SYMBOLS);
   localparam int RADIX_W = $clog2(MAX_SYMBOLS + 1);
   localparam int PROD_W  = sirt_pkg::MAG_W + RADIX_W;

   logic [sirt_pkg::CFG_W-1:0]     cfg_ff [sirt_pkg::SYM_WORDS];
   logic [sirt_pkg::CHAR_W-1:0]    sym_bytes [MAX_SYMBOLS];

   sirt_pkg::alpha_state_type      state_ff, state_in;
   logic [DIGIT_W-1:0]             scan_idx_ff, scan_idx_in;
   logic                           found_ff, found_in;
   logic [RADIX_W-1:0]             len_ff, len_in;
   logic                           bad_ff, bad_in;
   logic                           valid_ff, valid_in;
   logic [RADIX_W-1:0]             radix_ff, radix_in;
   logic [sirt_pkg::SHIFT_W-1:0]   dbits_ff, dbits_in;
   logic [sirt_pkg::POW_IDX_W-1:0] top_ff, top_in;
   logic [sirt_pkg::MAG_W-1:0]     pcur_ff, pcur_in;
   logic [sirt_pkg::POW_IDX_W-1:0] pidx_ff, pidx_in;
   logic [sirt_pkg::MAG_W-1:0]     pow_ff [sirt_pkg::POW_DEPTH];

   logic [sirt_pkg::CHAR_W-1:0]    cur;
   logic                           dup;
   logic                           scan_last;
   logic [RADIX_W-1:0]             len_final;
   logic [PROD_W-1:0]              prod;
   logic                           pow_stop;

   // bits needed for the largest digit of the radix
   function automatic logic [sirt_pkg::SHIFT_W-1:0] bits_of(input logic [RADIX_W-1:0] v);
      logic [sirt_pkg::SHIFT_W-1:0] r;
      r = '0;
      for (int i = 0; i < RADIX_W; i++) begin
         if (v[i]) begin
            r = sirt_pkg::SHIFT_W'(i + 1);
         end
      end
      return r;
   endfunction

   always_comb begin
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         sym_bytes[i] = cfg_ff[i >> 3][(i & 7) * sirt_pkg::CHAR_W +: sirt_pkg::CHAR_W];
      end
   end

   assign cur       = sym_bytes[scan_idx_ff];
   assign scan_last = scan_idx_ff == DIGIT_W'(MAX_SYMBOLS - 1);
   assign prod      = PROD_W'(pcur_ff) * PROD_W'(radix_ff);
   assign pow_stop  = (prod > PROD_W'(sirt_pkg::POW_LIMIT))
                   || (pidx_ff == sirt_pkg::POW_IDX_W'(sirt_pkg::POW_DEPTH - 1));

   // compare the current symbol against every earlier one
   always_comb begin
      dup = 1'b0;
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
         if ((DIGIT_W'(j) < scan_idx_ff) && (sym_bytes[j] == cur)) begin
            dup = 1'b1;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      found_in    = found_ff;
      len_in      = len_ff;
      bad_in      = bad_ff;
      valid_in    = valid_ff;
      radix_in    = radix_ff;
      dbits_in    = dbits_ff;
      top_in      = top_ff;
      pcur_in     = pcur_ff;
      pidx_in     = pidx_ff;
      len_final   = len_ff;

      unique case (state_ff)
         sirt_pkg::A_SCAN: begin
            if (!found_ff) begin
               if (cur == sirt_pkg::CHAR_NUL) begin
                  found_in = 1'b1;
                  len_in   = RADIX_W'(scan_idx_ff);
               end else if (cur == sirt_pkg::CHAR_MINUS || cur == sirt_pkg::CHAR_PLUS || dup) begin
                  bad_in = 1'b1;
               end
            end
            len_final = found_in ? len_in : RADIX_W'(MAX_SYMBOLS);
            if (scan_last) begin
               radix_in = len_final;
               dbits_in = bits_of(len_final - RADIX_W'(1));
               valid_in = !bad_in && (len_final >= RADIX_W'(2));
               pcur_in  = sirt_pkg::MAG_W'(1);
               pidx_in  = '0;
               state_in = valid_in ? sirt_pkg::A_POW : sirt_pkg::A_DONE;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         sirt_pkg::A_POW: begin
            if (pow_stop) begin
               top_in   = pidx_ff;
               state_in = sirt_pkg::A_DONE;
            end else begin
               pcur_in = prod[sirt_pkg::MAG_W-1:0];
               pidx_in = pidx_ff + 1'b1;
            end
         end
         sirt_pkg::A_DONE: begin
            state_in = sirt_pkg::A_DONE;
         end
         default: begin
            state_in = sirt_pkg::A_SCAN;
         end
      endcase

      // any write restarts the check
      if (csr_wr_en) begin
         state_in    = sirt_pkg::A_SCAN;
         scan_idx_in = '0;
         found_in    = 1'b0;
         bad_in      = 1'b0;
         valid_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sirt_pkg::A_SCAN;
         scan_idx_ff <= '0;
         found_ff    <= 1'b0;
         len_ff      <= '0;
         bad_ff      <= 1'b0;
         valid_ff    <= 1'b0;
         radix_ff    <= '0;
         dbits_ff    <= '0;
         top_ff      <= '0;
         pcur_ff     <= '0;
         pidx_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         found_ff    <= found_in;
         len_ff      <= len_in;
         bad_ff      <= bad_in;
         valid_ff    <= valid_in;
         radix_ff    <= radix_in;
         dbits_ff    <= dbits_in;
         top_ff      <= top_in;
         pcur_ff     <= pcur_in;
         pidx_ff     <= pidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < sirt_pkg::SYM_WORDS; w++) begin
            cfg_ff[w] <= '0;
         end
      end else if (csr_wr_en && (csr_index < sirt_pkg::CSR_IDX_W'(sirt_pkg::SYM_WORDS))) begin
         cfg_ff[csr_index[sirt_pkg::SYM_IDX_W-1:0]] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sirt_pkg::A_POW) begin
         pow_ff[pidx_ff] <= pcur_ff;
      end
   end

   assign stat.ready = state_ff == sirt_pkg::A_DONE;
   assign stat.valid = valid_ff;
   assign stat.top   = top_ff;
   assign stat.dbits = dbits_ff;
   assign pow_data   = pow_ff[pow_idx];
   assign sym_data   = sym_bytes[sym_idx];

endmodule

// File: hdl/sirt_back.sv
// digit engine: walks down the radix powers, one quotient bit a cycle unless a stalled
// rsp holds the last bit of a digit, and drives the output register; depends on sirt_pkg

module sirt_back #(
   parameter int MAX_SYMBOLS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sirt_pkg::alpha_stat_type            stat,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  sirt_pkg::item_type                  pop_item,
   output logic [sirt_pkg::POW_IDX_W-1:0]      pow_idx,
   input  logic [sirt_pkg::MAG_W-1:0]          pow_data,
   output logic [$clog2(MAX_SYMBOLS)-1:0]      sym_idx,
   input  logic [sirt_pkg::CHAR_W-1:0]         sym_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sirt_pkg::CHAR_W-1:0]         rsp_out_char,
   output logic                                rsp_last_char
);

   localparam int DIGIT_W = $clog2(MAX_SYMBOLS);
   localparam int TRIAL_W = sirt_pkg::MAG_W + DIGIT_W;

   sirt_pkg::back_state_type       state_ff, state_in;
   logic [sirt_pkg::MAG_W-1:0]     rem_ff, rem_in;
   logic [sirt_pkg::POW_IDX_W-1:0] k_ff, k_in;
   logic [sirt_pkg::SHIFT_W-1:0]   b_ff, b_in;
   logic [DIGIT_W-1:0]             d_ff, d_in;
   logic                           ov_ff, ov_in;
   logic [sirt_pkg::CHAR_W-1:0]    och_ff, och_in;
   logic                           olast_ff, olast_in;

   logic                           can_emit;
   logic [TRIAL_W-1:0]             trial;
   logic                           take;
   logic [sirt_pkg::MAG_W-1:0]     rem_step;
   logic [DIGIT_W-1:0]             d_next;

   assign can_emit = !ov_ff || rsp_ready;
   assign pow_idx  = k_ff;
   assign trial    = TRIAL_W'(pow_data) << b_ff;
   assign take     = TRIAL_W'(rem_ff) >= trial;
   assign rem_step = take ? (rem_ff - trial[sirt_pkg::MAG_W-1:0]) : rem_ff;
   assign d_next   = take ? (d_ff | (DIGIT_W'(1) << b_ff)) : d_ff;
   assign sym_idx  = d_next;

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      k_in      = k_ff;
      b_in      = b_ff;
      d_in      = d_ff;
      ov_in     = ov_ff && !rsp_ready;
      och_in    = och_ff;
      olast_in  = olast_ff;
      pop_ready = 1'b0;

      unique case (state_ff)
         sirt_pkg::B_IDLE: begin
            pop_ready = stat.ready;
            if (pop_valid && stat.ready && stat.valid) begin
               rem_in   = pop_item.mag;
               k_in     = stat.top;
               state_in = pop_item.neg ? sirt_pkg::B_SIGN : sirt_pkg::B_SKIP;
            end
         end
         sirt_pkg::B_SIGN: begin
            if (can_emit) begin
               ov_in    = 1'b1;
               och_in   = sirt_pkg::CHAR_MINUS;
               olast_in = 1'b0;
               state_in = sirt_pkg::B_SKIP;
            end
         end
         sirt_pkg::B_SKIP: begin
            // drop leading zero digits
            if ((k_ff != '0) && (rem_ff < pow_data)) begin
               k_in = k_ff - 1'b1;
            end else begin
               b_in     = stat.dbits - sirt_pkg::SHIFT_W'(1);
               d_in     = '0;
               state_in = sirt_pkg::B_DIGIT;
            end
         end
         sirt_pkg::B_DIGIT: begin
            if (b_ff != '0) begin
               rem_in = rem_step;
               d_in   = d_next;
               b_in   = b_ff - 1'b1;
            end else if (can_emit) begin
               rem_in   = rem_step;
               ov_in    = 1'b1;
               och_in   = sym_data;
               olast_in = k_ff == '0;
               if (k_ff == '0) begin
                  state_in = sirt_pkg::B_IDLE;
               end else begin
                  k_in = k_ff - 1'b1;
                  b_in = stat.dbits - sirt_pkg::SHIFT_W'(1);
                  d_in = '0;
               end
            end
         end
         default: begin
            state_in = sirt_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sirt_pkg::B_IDLE;
         ov_ff    <= 1'b0;
         k_ff     <= '0;
         b_ff     <= '0;
         d_ff     <= '0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         k_ff     <= k_in;
         b_ff     <= b_in;
         d_ff     <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      och_ff   <= och_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid     = ov_ff;
   assign rsp_out_char  = och_ff;
   assign rsp_last_char = olast_ff;

endmodule

// File: hdl/signed_int_to_custom_radix_text.sv
// top level: signed 32-bit number to text in a configurable radix
// depends on sirt_pkg, sirt_front, sirt_queue, sirt_alpha, sirt_back and the defines header
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  req      | in        | req_valid / req_ready | req_value (signed 32)
//  rsp      | out       | rsp_valid / rsp_ready | rsp_out_char (8), rsp_last_char
//  csr      | in        | csr_wr_en             | csr_index (3), csr_wdata (64)
//
// the digit engine emits the sign of a negative number, skips leading zero digits, then builds
// each digit bit by bit; top is the index of the highest radix power not above 2^31
// after reset or a csr write the checker scans all MAX_SYMBOLS symbols, then the radix powers
// reset is synchronous and active high; all symbol words reset to zero (invalid alphabet)
// a stalled rsp holds the output register; the front and the two-entry queue keep
// taking words until they are full while the digit engine or the alphabet check holds them off

`include "signed_int_to_custom_radix_text_defines.svh"

module signed_int_to_custom_radix_text #(
   parameter int MAX_SYMBOLS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // input words
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [sirt_pkg::VALUE_W-1:0] req_value,
   // output characters
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sirt_pkg::CHAR_W-1:0]         rsp_out_char,
   output logic                                rsp_last_char,
   // symbol registers
   input  logic                                csr_wr_en,
   input  logic [sirt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sirt_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int DIGIT_W = $clog2(MAX_SYMBOLS);

   // front stage to queue
   logic                           f_push_valid;
   logic                           f_push_ready;
   sirt_pkg::item_type             f_push_item;

   // queue to digit engine
   logic                           q_pop_valid;
   logic                           q_pop_ready;
   sirt_pkg::item_type             q_pop_item;

   // alphabet status and lookups
   sirt_pkg::alpha_stat_type       alpha_stat;
   logic [sirt_pkg::POW_IDX_W-1:0] pow_idx;
   logic [sirt_pkg::MAG_W-1:0]     pow_data;
   logic [DIGIT_W-1:0]             sym_idx;
   logic [sirt_pkg::CHAR_W-1:0]    sym_data;

   // sign split, one word held
   sirt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (f_push_valid),
      .push_ready (f_push_ready),
      .push_item  (f_push_item)
   );

   // decouples the front from the digit engine
   sirt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_push_valid),
      .push_ready (f_push_ready),
      .push_item  (f_push_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item)
   );

   // symbol registers, validity check, powers of the radix
   sirt_alpha #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_alpha (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (alpha_stat),
      .pow_idx   (pow_idx),
      .pow_data  (pow_data),
      .sym_idx   (sym_idx),
      .sym_data  (sym_data)
   );

   // digits most significant first; invalid alphabet drops the word
   sirt_back #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .stat          (alpha_stat),
      .pop_valid     (q_pop_valid),
      .pop_ready     (q_pop_ready),
      .pop_item      (q_pop_item),
      .pow_idx       (pow_idx),
      .pow_data      (pow_data),
      .sym_idx       (sym_idx),
      .sym_data      (sym_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   // a word leaves the queue only once the alphabet check is done
   `SIRT_ASSERT_IMPLIES(a_pop_after_check, clock, reset, q_pop_valid && q_pop_ready, alpha_stat.ready, "word taken before alphabet check finished")

   // a csr write always restarts the check
   `SIRT_ASSERT_NEXT(a_write_restarts_check, clock, reset, csr_wr_en, !alpha_stat.ready, "alphabet check not restarted by csr write")

   // a valid alphabet has at least the first radix power
   `SIRT_ASSERT_IMPLIES(a_valid_has_power, clock, reset, alpha_stat.ready && alpha_stat.valid, alpha_stat.top != '0, "valid alphabet without radix powers")

   // the sign character is never the final one
   `SIRT_ASSERT_IMPLIES(a_sign_not_last, clock, reset, rsp_valid && (rsp_out_char == sirt_pkg::CHAR_MINUS), !rsp_last_char, "sign character marked as last")

endmodule
